@@ hw/rtl/elv_pkg.sv @@
package elv_pkg;

   // Field widths of one result
   localparam int KIND_WIDTH    = 4;
   localparam int START_WIDTH   = 12;
   localparam int LENGTH_WIDTH  = 13;
   localparam int VERDICT_WIDTH = 4;

   // Results one input character can cause at most
   localparam int SLOTS = 3;
   localparam int SLOT_INDEX_WIDTH = 2;

   // Entries in the queue between tokenizer and checker
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_INDEX_WIDTH = 2;
   localparam int QUEUE_COUNT_WIDTH = 3;

   typedef logic [KIND_WIDTH-1:0]    kind_type;
   typedef logic [VERDICT_WIDTH-1:0] verdict_type;

   // Token kinds
   localparam kind_type K_NUM   = 4'd0;
   localparam kind_type K_VAR   = 4'd1;
   localparam kind_type K_PLUS  = 4'd2;
   localparam kind_type K_MINUS = 4'd3;
   localparam kind_type K_TIMES = 4'd4;
   localparam kind_type K_DIV   = 4'd5;
   localparam kind_type K_MOD   = 4'd6;
   localparam kind_type K_POW   = 4'd7;
   localparam kind_type K_LPAR  = 4'd8;
   localparam kind_type K_RPAR  = 4'd9;
   localparam kind_type K_UNK   = 4'd10;

   // Line verdicts
   localparam verdict_type V_OK      = 4'd0;
   localparam verdict_type V_PAREN   = 4'd1;
   localparam verdict_type V_START   = 4'd2;
   localparam verdict_type V_UNKNOWN = 4'd3;
   localparam verdict_type V_RPNUM   = 4'd4;
   localparam verdict_type V_NUMNUM  = 4'd5;
   localparam verdict_type V_SYNTAX  = 4'd6;
   localparam verdict_type V_RPLP    = 4'd7;
   localparam verdict_type V_END     = 4'd8;

   // Characters
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_MOD    = 8'h25;
   localparam logic [7:0] CH_LPAR   = 8'h28;
   localparam logic [7:0] CH_RPAR   = 8'h29;
   localparam logic [7:0] CH_TIMES  = 8'h2A;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_POINT  = 8'h2E;
   localparam logic [7:0] CH_DIV    = 8'h2F;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_POW    = 8'h5E;

   // One pending result: a token, or the verdict of the line
   typedef struct packed {
      logic                    is_verdict;
      kind_type                kind;
      logic [START_WIDTH-1:0]  start;
      logic [LENGTH_WIDTH-1:0] length;
   } slot_type;

   // All results of one input character, packed from slot 0 up
   typedef struct packed {
      slot_type [SLOTS-1:0]        slots;
      logic [SLOT_INDEX_WIDTH-1:0] count;
   } entry_type;

   // Variables behave as numbers in every adjacency check
   function automatic logic numeric_kind(input kind_type k);
      numeric_kind = (k == K_NUM) || (k == K_VAR);
   endfunction

endpackage

@@ hw/rtl/elv_front.sv @@
module elv_front #(
   parameter int MAX_LINE = 4096
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   input  logic [7:0]          req_char_code,
   input  logic                req_has_char,
   input  logic                req_end_of_line,
   input  logic                q_full,
   output logic                req_full,
   output logic                q_push,
   output elv_pkg::entry_type  q_entry
);
   import elv_pkg::*;

   localparam int PW = $clog2(MAX_LINE + 1);

   function automatic logic is_digit(input logic [7:0] c);
      is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic var_stop(input logic [7:0] c);
      var_stop = (c == CH_PLUS) || (c == CH_MOD) || (c == CH_LPAR) || (c == CH_RPAR) ||
                 (c == CH_DIV) || (c == CH_TIMES) || (c == CH_POW);
   endfunction

   logic [PW-1:0] position_ff, position_in;
   logic          open_active_ff, open_active_in;
   kind_type      open_kind_ff, open_kind_in;
   logic [PW-1:0] open_start_ff, open_start_in;
   logic          point_seen_ff, point_seen_in;
   kind_type      prev_kind_ff, prev_kind_in;
   logic          any_token_ff, any_token_in;

   logic          accept;
   logic          in_range;
   logic          extend;
   logic          close_old;
   kind_type      prev_eff;
   logic          any_eff;
   kind_type      k;
   logic          opens;
   logic          new_tok;
   logic          opens_tok;
   logic          single;
   logic [PW-1:0] position_nx;
   logic          open_act1;
   kind_type      kind1;
   logic [PW-1:0] start1;
   logic          close_eol;
   logic [3:0]    cand_valid;
   slot_type      cand [4];
   entry_type     entry;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   always_comb begin
      logic [SLOT_INDEX_WIDTH-1:0] n;

      in_range = req_has_char && (position_ff < PW'(MAX_LINE));

      extend = 1'b0;
      if (open_active_ff) begin
         if (open_kind_ff == K_NUM) begin
            extend = is_digit(req_char_code) ||
                     ((req_char_code == CH_POINT) && !point_seen_ff);
         end else begin
            extend = !var_stop(req_char_code);
         end
      end
      extend    = extend && in_range;
      close_old = in_range && open_active_ff && !extend;

      // unary minus sees the token just closed by this character
      prev_eff = close_old ? open_kind_ff : prev_kind_ff;
      any_eff  = close_old || any_token_ff;

      k     = K_UNK;
      opens = 1'b0;
      case (req_char_code)
         CH_DOLLAR: begin
            k     = K_VAR;
            opens = 1'b1;
         end
         CH_PLUS:  k = K_PLUS;
         CH_TIMES: k = K_TIMES;
         CH_DIV:   k = K_DIV;
         CH_MOD:   k = K_MOD;
         CH_POW:   k = K_POW;
         CH_LPAR:  k = K_LPAR;
         CH_RPAR:  k = K_RPAR;
         CH_MINUS: begin
            if (!any_eff || (!numeric_kind(prev_eff) && prev_eff != K_RPAR)) begin
               k     = K_NUM;
               opens = 1'b1;
            end else begin
               k = K_MINUS;
            end
         end
         default: begin
            if (is_digit(req_char_code)) begin
               k     = K_NUM;
               opens = 1'b1;
            end
         end
      endcase

      new_tok     = in_range && !extend;
      opens_tok   = new_tok && opens;
      single      = new_tok && !opens;
      position_nx = position_ff + PW'(in_range);
      open_act1   = in_range ? (extend || opens_tok) : open_active_ff;
      kind1       = opens_tok ? k : open_kind_ff;
      start1      = opens_tok ? position_ff : open_start_ff;
      close_eol   = req_end_of_line && open_act1;

      cand_valid = {req_end_of_line, close_eol, single, close_old};

      cand[0].is_verdict = 1'b0;
      cand[0].kind       = open_kind_ff;
      cand[0].start      = START_WIDTH'(open_start_ff);
      cand[0].length     = LENGTH_WIDTH'(position_ff - open_start_ff);

      cand[1].is_verdict = 1'b0;
      cand[1].kind       = k;
      cand[1].start      = START_WIDTH'(position_ff);
      cand[1].length     = LENGTH_WIDTH'(1);

      cand[2].is_verdict = 1'b0;
      cand[2].kind       = kind1;
      cand[2].start      = START_WIDTH'(start1);
      cand[2].length     = LENGTH_WIDTH'(position_nx - start1);

      cand[3].is_verdict = 1'b1;
      cand[3].kind       = K_NUM;
      cand[3].start      = START_WIDTH'(position_nx);
      cand[3].length     = '0;

      // at most three candidates are ever valid together
      entry = '0;
      n     = '0;
      for (int i = 0; i < 4; i++) begin
         if (cand_valid[i]) begin
            entry.slots[n] = cand[i];
            n              = n + SLOT_INDEX_WIDTH'(1);
         end
      end
      entry.count = n - SLOT_INDEX_WIDTH'(1);
   end

   assign q_push  = accept && (cand_valid != 4'b0000);
   assign q_entry = entry;

   always_comb begin
      position_in    = position_ff;
      open_active_in = open_active_ff;
      open_kind_in   = open_kind_ff;
      open_start_in  = open_start_ff;
      point_seen_in  = point_seen_ff;
      prev_kind_in   = prev_kind_ff;
      any_token_in   = any_token_ff;
      if (accept) begin
         if (req_end_of_line) begin
            position_in    = '0;
            open_active_in = 1'b0;
            open_kind_in   = K_NUM;
            open_start_in  = '0;
            point_seen_in  = 1'b0;
            prev_kind_in   = K_NUM;
            any_token_in   = 1'b0;
         end else begin
            position_in    = position_nx;
            open_active_in = open_act1;
            open_kind_in   = kind1;
            open_start_in  = start1;
            if (opens_tok) begin
               point_seen_in = 1'b0;
            end else if (extend && req_char_code == CH_POINT) begin
               point_seen_in = 1'b1;
            end
            if (single) begin
               prev_kind_in = k;
               any_token_in = 1'b1;
            end else if (close_old) begin
               prev_kind_in = open_kind_ff;
               any_token_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff    <= '0;
         open_active_ff <= 1'b0;
         open_kind_ff   <= K_NUM;
         open_start_ff  <= '0;
         point_seen_ff  <= 1'b0;
         prev_kind_ff   <= K_NUM;
         any_token_ff   <= 1'b0;
      end else begin
         position_ff    <= position_in;
         open_active_ff <= open_active_in;
         open_kind_ff   <= open_kind_in;
         open_start_ff  <= open_start_in;
         point_seen_ff  <= point_seen_in;
         prev_kind_ff   <= prev_kind_in;
         any_token_ff   <= any_token_in;
      end
   end

endmodule

@@ hw/rtl/elv_queue.sv @@
module elv_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  elv_pkg::entry_type  push_entry,
   input  logic                pop,
   output elv_pkg::entry_type  head_entry,
   output logic                not_empty,
   output logic                full
);
   import elv_pkg::*;

   entry_type                    store_ff [QUEUE_DEPTH];
   logic [QUEUE_INDEX_WIDTH-1:0] head_ff, head_in;
   logic [QUEUE_INDEX_WIDTH-1:0] tail_ff, tail_in;
   logic [QUEUE_COUNT_WIDTH-1:0] count_ff, count_in;
   logic                         do_push;
   logic                         do_pop;

   assign full       = (count_ff == QUEUE_COUNT_WIDTH'(QUEUE_DEPTH));
   assign not_empty  = (count_ff != '0);
   assign head_entry = store_ff[head_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && not_empty;

   always_comb begin
      head_in  = head_ff + QUEUE_INDEX_WIDTH'(do_pop);
      tail_in  = tail_ff + QUEUE_INDEX_WIDTH'(do_push);
      count_in = count_ff + QUEUE_COUNT_WIDTH'(do_push) - QUEUE_COUNT_WIDTH'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[tail_ff] <= push_entry;
      end
   end

endmodule

@@ hw/rtl/elv_back.sv @@
module elv_back #(
   parameter int MAX_DEPTH = 255
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  q_not_empty,
   input  elv_pkg::entry_type                    q_head,
   output logic                                  q_pop,
   input  logic                                  rsp_pop,
   output logic                                  rsp_empty,
   output logic [elv_pkg::KIND_WIDTH-1:0]        rsp_token_kind,
   output logic [elv_pkg::START_WIDTH-1:0]       rsp_token_start,
   output logic [elv_pkg::LENGTH_WIDTH-1:0]      rsp_token_length,
   output logic [elv_pkg::VERDICT_WIDTH-1:0]     rsp_verdict,
   output logic                                  rsp_is_last
);
   import elv_pkg::*;

   localparam int DW = $clog2(MAX_DEPTH + 1);

   logic                        out_valid_ff, out_valid_in;
   kind_type                    out_kind_ff, out_kind_in;
   logic [START_WIDTH-1:0]      out_start_ff, out_start_in;
   logic [LENGTH_WIDTH-1:0]     out_length_ff, out_length_in;
   verdict_type                 out_verdict_ff, out_verdict_in;
   logic                        out_last_ff, out_last_in;
   logic [SLOT_INDEX_WIDTH-1:0] sub_ff, sub_in;
   kind_type                    prev_kind_ff, prev_kind_in;
   logic                        any_token_ff, any_token_in;
   logic [DW-1:0]               depth_ff, depth_in;
   logic                        paren_fault_ff, paren_fault_in;
   verdict_type                 first_fault_ff, first_fault_in;

   logic        advance;
   logic        last_slot;
   slot_type    slot;
   verdict_type fault;
   verdict_type line_verdict;

   assign advance   = q_not_empty && (!out_valid_ff || rsp_pop);
   assign slot      = q_head.slots[sub_ff];
   assign last_slot = (sub_ff == q_head.count);
   assign q_pop     = advance && last_slot;

   // adjacency check of the token against the one before it
   always_comb begin
      fault = V_OK;
      if (!any_token_ff) begin
         if (slot.kind != K_LPAR && !numeric_kind(slot.kind)) begin
            fault = V_START;
         end
      end else if (slot.kind == K_UNK) begin
         fault = V_UNKNOWN;
      end else if (numeric_kind(slot.kind)) begin
         if (prev_kind_ff == K_RPAR) begin
            fault = V_RPNUM;
         end else if (numeric_kind(prev_kind_ff)) begin
            fault = V_NUMNUM;
         end
      end else if (slot.kind == K_LPAR) begin
         if (prev_kind_ff == K_RPAR) begin
            fault = V_RPLP;
         end
      end else if (!numeric_kind(prev_kind_ff) && prev_kind_ff != K_RPAR) begin
         fault = V_SYNTAX;
      end
   end

   always_comb begin
      if (paren_fault_ff || depth_ff != '0) begin
         line_verdict = V_PAREN;
      end else if (first_fault_ff != V_OK) begin
         line_verdict = first_fault_ff;
      end else if (!any_token_ff) begin
         line_verdict = V_START;
      end else if (!numeric_kind(prev_kind_ff) && prev_kind_ff != K_RPAR) begin
         line_verdict = V_END;
      end else begin
         line_verdict = V_OK;
      end
   end

   always_comb begin
      out_valid_in   = out_valid_ff && !rsp_pop;
      out_kind_in    = out_kind_ff;
      out_start_in   = out_start_ff;
      out_length_in  = out_length_ff;
      out_verdict_in = out_verdict_ff;
      out_last_in    = out_last_ff;
      sub_in         = sub_ff;
      prev_kind_in   = prev_kind_ff;
      any_token_in   = any_token_ff;
      depth_in       = depth_ff;
      paren_fault_in = paren_fault_ff;
      first_fault_in = first_fault_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         sub_in       = last_slot ? '0 : sub_ff + SLOT_INDEX_WIDTH'(1);
         if (slot.is_verdict) begin
            out_kind_in    = K_NUM;
            out_start_in   = slot.start;
            out_length_in  = '0;
            out_verdict_in = line_verdict;
            out_last_in    = 1'b1;
            prev_kind_in   = K_NUM;
            any_token_in   = 1'b0;
            depth_in       = '0;
            paren_fault_in = 1'b0;
            first_fault_in = V_OK;
         end else begin
            out_kind_in    = slot.kind;
            out_start_in   = slot.start;
            out_length_in  = slot.length;
            out_verdict_in = V_OK;
            out_last_in    = 1'b0;
            prev_kind_in   = slot.kind;
            any_token_in   = 1'b1;
            if (first_fault_ff == V_OK) begin
               first_fault_in = fault;
            end
            if (slot.kind == K_LPAR) begin
               if (depth_ff >= DW'(MAX_DEPTH)) begin
                  paren_fault_in = 1'b1;
               end else begin
                  depth_in = depth_ff + DW'(1);
               end
            end else if (slot.kind == K_RPAR) begin
               if (depth_ff == '0) begin
                  paren_fault_in = 1'b1;
               end else begin
                  depth_in = depth_ff - DW'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff   <= 1'b0;
         sub_ff         <= '0;
         prev_kind_ff   <= K_NUM;
         any_token_ff   <= 1'b0;
         depth_ff       <= '0;
         paren_fault_ff <= 1'b0;
         first_fault_ff <= V_OK;
      end else begin
         out_valid_ff   <= out_valid_in;
         sub_ff         <= sub_in;
         prev_kind_ff   <= prev_kind_in;
         any_token_ff   <= any_token_in;
         depth_ff       <= depth_in;
         paren_fault_ff <= paren_fault_in;
         first_fault_ff <= first_fault_in;
      end
   end

   always_ff @(posedge clock) begin
      out_kind_ff    <= out_kind_in;
      out_start_ff   <= out_start_in;
      out_length_ff  <= out_length_in;
      out_verdict_ff <= out_verdict_in;
      out_last_ff    <= out_last_in;
   end

   assign rsp_empty        = !out_valid_ff;
   assign rsp_token_kind   = out_kind_ff;
   assign rsp_token_start  = out_start_ff;
   assign rsp_token_length = out_length_ff;
   assign rsp_verdict      = out_verdict_ff;
   assign rsp_is_last      = out_last_ff;

endmodule

@@ hw/rtl/expression_lexer_validator.sv @@
// Channel   | Ports                                             | Handshake
// ----------+---------------------------------------------------+---------------------------
// request   | req_char_code, req_has_char, req_end_of_line      | req_push, req_full
// result    | rsp_token_kind, rsp_token_start, rsp_token_length, | rsp_pop, rsp_empty
//           | rsp_verdict, rsp_is_last                          |
//
// One request is taken per cycle while the 4-entry queue between the tokenizer and
// the checker has room. Each request yields 0 to 3 results; the checker's output
// register hands out one result per cycle while rsp_pop is high and the queue holds entries.
// A result passes through a queue entry and then the checker's output register.
// Synchronous reset clears both halves; no clearing pass is needed.
// A stalled result side fills the queue, which then raises req_full.
module expression_lexer_validator #(
   parameter int MAX_LINE  = 4096,
   parameter int MAX_DEPTH = 255
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_push,
   output logic                                  req_full,
   input  logic [7:0]                            req_char_code,
   input  logic                                  req_has_char,
   input  logic                                  req_end_of_line,
   input  logic                                  rsp_pop,
   output logic                                  rsp_empty,
   output logic [elv_pkg::KIND_WIDTH-1:0]        rsp_token_kind,
   output logic [elv_pkg::START_WIDTH-1:0]       rsp_token_start,
   output logic [elv_pkg::LENGTH_WIDTH-1:0]      rsp_token_length,
   output logic [elv_pkg::VERDICT_WIDTH-1:0]     rsp_verdict,
   output logic                                  rsp_is_last
);
   import elv_pkg::*;

   // tokenizer -> queue
   logic      q_push;
   entry_type q_entry;
   logic      q_full;
   // queue -> checker
   entry_type q_head;
   logic      q_not_empty;
   logic      q_pop;

   // Front: finds token boundaries, decides unary minus, tracks position.
   // It keeps its own copy of the last token kind for the unary minus rule.
   elv_front #(
      .MAX_LINE (MAX_LINE)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_char_code   (req_char_code),
      .req_has_char    (req_has_char),
      .req_end_of_line (req_end_of_line),
      .q_full          (q_full),
      .req_full        (req_full),
      .q_push          (q_push),
      .q_entry         (q_entry)
   );

   // Short queue: one entry holds every result of one request.
   elv_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .pop        (q_pop),
      .head_entry (q_head),
      .not_empty  (q_not_empty),
      .full       (q_full)
   );

   // Back: adjacency and nesting checks, first-fault capture, verdict,
   // and the output register that the result side pops from.
   elv_back #(
      .MAX_DEPTH (MAX_DEPTH)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_not_empty      (q_not_empty),
      .q_head           (q_head),
      .q_pop            (q_pop),
      .rsp_pop          (rsp_pop),
      .rsp_empty        (rsp_empty),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_token_start  (rsp_token_start),
      .rsp_token_length (rsp_token_length),
      .rsp_verdict      (rsp_verdict),
      .rsp_is_last      (rsp_is_last)
   );

endmodule

@@ bench/expression_lexer_validator_tb.sv @@
`timescale 1ns / 100ps

module expression_lexer_validator_tb;

   import elv_pkg::*;

   localparam int LINE_LIMIT   = 4096;
   localparam int DEPTH_LIMIT  = 255;
   localparam int RANDOM_ITEMS = 190;
   localparam int HOLD_CYCLES  = 300;   // long receiver stall, fills the internal queue
   localparam int DRAIN_TAIL   = 20;    // quiet cycles after the last token, catches strays
   localparam int BAD_SHOWN    = 10;

   localparam logic [7:0] CH_NUL      = 8'h00;
   localparam logic [7:0] CH_TOP      = 8'hFF;
   localparam logic [7:0] CH_LETTER_A = 8'h61;

   // One token or line verdict, as seen on the rsp_ ports
   typedef struct packed {
      kind_type                kind;
      logic [START_WIDTH-1:0]  start;
      logic [LENGTH_WIDTH-1:0] length;
      verdict_type             verdict;
      logic                    is_last;
   } lex_result_type;

   // Directed stimulus row; want is used only when typed is set
   typedef struct packed {
      logic [7:0]     code;
      logic           has;
      logic           eol;
      logic           typed;
      lex_result_type want;
   } table_row_type;

   logic                     clock;
   logic                     reset            = 1'b1;
   logic                     req_push         = 1'b0;
   logic                     req_full;
   logic [7:0]               req_char_code    = '0;
   logic                     req_has_char     = 1'b0;
   logic                     req_end_of_line  = 1'b0;
   logic                     rsp_pop          = 1'b0;
   logic                     rsp_empty;
   logic [KIND_WIDTH-1:0]    rsp_token_kind;
   logic [START_WIDTH-1:0]   rsp_token_start;
   logic [LENGTH_WIDTH-1:0]  rsp_token_length;
   logic [VERDICT_WIDTH-1:0] rsp_verdict;
   logic                     rsp_is_last;

   expression_lexer_validator #(
      .MAX_LINE  (LINE_LIMIT),
      .MAX_DEPTH (DEPTH_LIMIT)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_char_code    (req_char_code),
      .req_has_char     (req_has_char),
      .req_end_of_line  (req_end_of_line),
      .rsp_pop          (rsp_pop),
      .rsp_empty        (rsp_empty),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_token_start  (rsp_token_start),
      .rsp_token_length (rsp_token_length),
      .rsp_verdict      (rsp_verdict),
      .rsp_is_last      (rsp_is_last)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case the block hangs
   initial begin
      #30_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // ---------------------------------------------------------------
   // Tokenizer prediction: per-line state, reset after every verdict
   // ---------------------------------------------------------------
   lex_result_type pending_tokens[$];   // tokens and verdicts still owed by the block

   int          line_pos;
   logic        run_open;            // a number or variable still collecting characters
   kind_type    run_kind;
   int          run_start;
   logic        run_point;
   kind_type    last_kind;
   logic        seen_token;
   int          depth;
   logic        depth_fault;
   verdict_type first_error;

   int          mismatches = 0;
   int          sent_items = 0;
   logic        send_quiet = 1'b0;   // sender offers back to back
   logic        recv_quiet = 1'b0;   // receiver pops back to back
   logic        rsp_hold   = 1'b0;   // asks the receiver for one long stall

   logic [7:0]    line_buf[$];
   table_row_type dir_rows[$];

   function automatic logic is_operand(kind_type k);
      return k == K_NUM || k == K_VAR;
   endfunction

   function automatic logic is_digit_char(logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
   endfunction

   // Characters that end a variable name ('-' does not)
   function automatic logic ends_variable(logic [7:0] c);
      return c == CH_PLUS || c == CH_MOD || c == CH_LPAR || c == CH_RPAR ||
             c == CH_DIV || c == CH_TIMES || c == CH_POW;
   endfunction

   function void clear_line();
      line_pos    = 0;
      run_open    = 1'b0;
      run_kind    = K_NUM;
      run_start   = 0;
      run_point   = 1'b0;
      last_kind   = K_NUM;
      seen_token  = 1'b0;
      depth       = 0;
      depth_fault = 1'b0;
      first_error = V_OK;
   endfunction

   function void note_error(verdict_type v);
      if (first_error == V_OK) begin
         first_error = v;
      end
   endfunction

   // Adjacency check against the previous token, nesting, then queue the token
   function void add_token(kind_type k, int start, int len);
      lex_result_type r;
      if (!seen_token) begin
         if (k != K_LPAR && !is_operand(k)) begin
            note_error(V_START);
         end
      end else if (k == K_UNK) begin
         note_error(V_UNKNOWN);
      end else if (is_operand(k)) begin
         if (last_kind == K_RPAR) begin
            note_error(V_RPNUM);
         end else if (is_operand(last_kind)) begin
            note_error(V_NUMNUM);
         end
      end else if (k == K_LPAR) begin
         if (last_kind == K_RPAR) begin
            note_error(V_RPLP);
         end
      end else if (!is_operand(last_kind) && last_kind != K_RPAR) begin
         note_error(V_SYNTAX);
      end

      if (k == K_LPAR) begin
         if (depth >= DEPTH_LIMIT) begin
            depth_fault = 1'b1;
         end else begin
            depth++;
         end
      end else if (k == K_RPAR) begin
         if (depth == 0) begin
            depth_fault = 1'b1;
         end else begin
            depth--;
         end
      end

      last_kind  = k;
      seen_token = 1'b1;
      r          = '0;
      r.kind     = k;
      r.start    = START_WIDTH'(start);
      r.length   = LENGTH_WIDTH'(len);
      pending_tokens.push_back(r);
   endfunction

   function void close_run();
      if (run_open) begin
         run_open = 1'b0;
         add_token(run_kind, run_start, line_pos - run_start);
      end
   endfunction

   function void predict_char(logic [7:0] c, logic has, logic eol);
      logic           grow;
      logic           opens;
      kind_type       k;
      lex_result_type v;
      if (has && line_pos < LINE_LIMIT) begin
         grow = 1'b0;
         if (run_open) begin
            if (run_kind == K_NUM) begin
               if (is_digit_char(c)) begin
                  grow = 1'b1;
               end else if (c == CH_POINT && !run_point) begin
                  run_point = 1'b1;
                  grow      = 1'b1;
               end
            end else if (!ends_variable(c)) begin
               grow = 1'b1;
            end
            if (!grow) begin
               close_run();
            end
         end
         if (!grow) begin
            k     = K_UNK;
            opens = 1'b0;
            case (c)
               CH_DOLLAR: begin
                  k     = K_VAR;
                  opens = 1'b1;
               end
               CH_PLUS:  k = K_PLUS;
               CH_TIMES: k = K_TIMES;
               CH_DIV:   k = K_DIV;
               CH_MOD:   k = K_MOD;
               CH_POW:   k = K_POW;
               CH_LPAR:  k = K_LPAR;
               CH_RPAR:  k = K_RPAR;
               CH_MINUS: begin
                  // unary unless it follows an operand or a closing paren
                  if (!seen_token || (!is_operand(last_kind) && last_kind != K_RPAR)) begin
                     k     = K_NUM;
                     opens = 1'b1;
                  end else begin
                     k = K_MINUS;
                  end
               end
               default: begin
                  if (is_digit_char(c)) begin
                     k     = K_NUM;
                     opens = 1'b1;
                  end
               end
            endcase
            if (opens) begin
               run_open  = 1'b1;
               run_kind  = k;
               run_start = line_pos;
               run_point = 1'b0;
            end else begin
               add_token(k, line_pos, 1);
            end
         end
         line_pos++;
      end

      if (eol) begin
         close_run();
         v         = '0;
         v.start   = START_WIDTH'(line_pos);   // wraps at 4096
         v.is_last = 1'b1;
         if (depth_fault || depth != 0) begin
            v.verdict = V_PAREN;
         end else if (first_error != V_OK) begin
            v.verdict = first_error;
         end else if (!seen_token) begin
            v.verdict = V_START;
         end else if (!is_operand(last_kind) && last_kind != K_RPAR) begin
            v.verdict = V_END;
         end else begin
            v.verdict = V_OK;
         end
         pending_tokens.push_back(v);
         clear_line();
      end
   endfunction

   // ---------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------

   // Drive one request at the falling edge, hold it until accepted, then predict.
   // push stays high on return so a zero gap keeps requests back to back.
   task automatic send_request(logic [7:0] c, logic has, logic eol);
      int gap;
      gap = send_quiet ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         @(negedge clock);
         req_push <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_push        <= 1'b1;
      req_char_code   <= c;
      req_has_char    <= has;
      req_end_of_line <= eol;
      @(posedge clock);
      while (req_full) @(posedge clock);
      predict_char(c, has, eol);
      if (has || eol) begin
         sent_items++;
      end
   endtask

   // Sender pause: nothing offered until every owed result is out
   task automatic wait_drained();
      @(negedge clock);
      req_push <= 1'b0;
      while (pending_tokens.size() != 0) @(negedge clock);
   endtask

   // Send line_buf; end of line rides on the last char or on a bare request.
   // Occasional no-char requests are sprinkled in; the block should ignore them.
   task automatic send_line();
      int   i;
      logic split;
      split = line_buf.size() == 0 || $urandom_range(0, 99) < 40;
      for (i = 0; i < line_buf.size(); i++) begin
         if ($urandom_range(0, 99) < 5) begin
            send_request(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         end
         send_request(line_buf[i], 1'b1, !split && i == line_buf.size() - 1);
      end
      if (split) begin
         send_request(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      end
   endtask

   function automatic logic [7:0] pick_operator();
      case ($urandom_range(0, 5))
         0:       return CH_PLUS;
         1:       return CH_MINUS;
         2:       return CH_TIMES;
         3:       return CH_DIV;
         4:       return CH_MOD;
         default: return CH_POW;
      endcase
   endfunction

   // Mostly characters the tokenizer cares about, sometimes anything at all
   function automatic logic [7:0] noise_char();
      if ($urandom_range(0, 1) == 0) begin
         return 8'($urandom_range(0, 255));
      end
      case ($urandom_range(0, 5))
         0:       return CH_DOLLAR;
         1:       return CH_POINT;
         2:       return CH_LPAR;
         3:       return CH_RPAR;
         4:       return pick_operator();
         default: return CH_ZERO + 8'($urandom_range(0, 9));
      endcase
   endfunction

   function void put_operand();
      int n;
      if ($urandom_range(0, 99) < 25) begin
         line_buf.push_back(CH_DOLLAR);
         n = $urandom_range(1, 3);
         repeat (n) line_buf.push_back(CH_LETTER_A + 8'($urandom_range(0, 25)));
      end else begin
         if ($urandom_range(0, 99) < 25) begin
            line_buf.push_back(CH_MINUS);
         end
         n = $urandom_range(1, 4);
         repeat (n) line_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
         if ($urandom_range(0, 99) < 25) begin
            line_buf.push_back(CH_POINT);
            n = $urandom_range(0, 2);
            repeat (n) line_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
         end
      end
   endfunction

   // Mostly well-formed expressions with random content; some get one char
   // damaged, the rest are plain noise lines
   function void build_line();
      int terms;
      int open_now;
      int i;
      int at;
      line_buf.delete();
      if ($urandom_range(0, 99) < 70) begin
         terms    = $urandom_range(1, 5);
         open_now = 0;
         for (i = 0; i < terms; i++) begin
            if (i > 0) begin
               line_buf.push_back(pick_operator());
            end
            while (open_now < 3 && $urandom_range(0, 99) < 20) begin
               line_buf.push_back(CH_LPAR);
               open_now++;
            end
            put_operand();
            while (open_now > 0 && $urandom_range(0, 99) < 30) begin
               line_buf.push_back(CH_RPAR);
               open_now--;
            end
         end
         repeat (open_now) line_buf.push_back(CH_RPAR);
         if ($urandom_range(0, 99) < 30) begin
            at = $urandom_range(0, line_buf.size() - 1);
            case ($urandom_range(0, 2))
               0:       line_buf[at] = noise_char();
               1:       line_buf.delete(at);
               default: line_buf.insert(at, noise_char());
            endcase
         end
      end else begin
         terms = $urandom_range(0, 10);
         repeat (terms) line_buf.push_back(noise_char());
      end
   endfunction

   function void put_row(logic [7:0] code, logic has, logic eol, logic typed,
                         verdict_type v, int at);
      table_row_type r;
      r                 = '0;
      r.code            = code;
      r.has             = has;
      r.eol             = eol;
      r.typed           = typed;
      r.want.start      = START_WIDTH'(at);
      r.want.verdict    = v;
      r.want.is_last    = 1'b1;
      dir_rows.push_back(r);
   endfunction

   initial begin : request_side
      int line_no;

      // Directed rows; typed ones carry the verdict of the line they close
      // no char, no end of line: ignored
      put_row(CH_NUL, 1'b0, 1'b0, 1'b0, V_OK, 0);
      // empty line
      put_row(CH_NUL, 1'b0, 1'b1, 1'b1, V_START, 0);
      // "(-1.2.)": unary minus, second point ends the number, lone point is unknown
      put_row(CH_LPAR,         1'b1, 1'b0, 1'b0, V_OK, 0);
      put_row(CH_MINUS,        1'b1, 1'b0, 1'b0, V_OK, 0);
      put_row(CH_ZERO + 8'd1,  1'b1, 1'b0, 1'b0, V_OK, 0);
      put_row(CH_POINT,        1'b1, 1'b0, 1'b0, V_OK, 0);
      put_row(CH_ZERO + 8'd2,  1'b1, 1'b0, 1'b0, V_OK, 0);
      put_row(CH_POINT,        1'b1, 1'b0, 1'b0, V_OK, 0);
      put_row(CH_RPAR,         1'b1, 1'b1, 1'b1, V_UNKNOWN, 7);
      // null char, then a closing paren with nothing open: paren fault wins
      put_row(CH_NUL,          1'b1, 1'b0, 1'b0, V_OK, 0);
      put_row(CH_RPAR,         1'b1, 1'b1, 1'b1, V_PAREN, 2);
      // "$a*2/3%4^5+6-9": every operator, binary minus, variable as operand
      put_row(CH_DOLLAR,       1'b1, 1'b0, 1'b0, V_OK, 0);
      put_row(CH_LETTER_A,     1'b1, 1'b0, 1'b0, V_OK, 0);
      put_row(CH_TIMES,        1'b1, 1'b0, 1'b0, V_OK, 0);
      put_row(CH_ZERO + 8'd2,  1'b1, 1'b0, 1'b0, V_OK, 0);
      put_row(CH_DIV,          1'b1, 1'b0, 1'b0, V_OK, 0);
      put_row(CH_ZERO + 8'd3,  1'b1, 1'b0, 1'b0, V_OK, 0);
      put_row(CH_MOD,          1'b1, 1'b0, 1'b0, V_OK, 0);
      put_row(CH_ZERO + 8'd4,  1'b1, 1'b0, 1'b0, V_OK, 0);
      put_row(CH_POW,          1'b1, 1'b0, 1'b0, V_OK, 0);
      put_row(CH_ZERO + 8'd5,  1'b1, 1'b0, 1'b0, V_OK, 0);
      put_row(CH_PLUS,         1'b1, 1'b0, 1'b0, V_OK, 0);
      put_row(CH_ZERO + 8'd6,  1'b1, 1'b0, 1'b0, V_OK, 0);
      put_row(CH_MINUS,        1'b1, 1'b0, 1'b0, V_OK, 0);
      put_row(CH_NINE,         1'b1, 1'b1, 1'b1, V_OK, 14);
      // lone unary minus, then the top char code
      put_row(CH_MINUS,        1'b1, 1'b0, 1'b0, V_OK, 0);
      put_row(CH_TOP,          1'b1, 1'b1, 1'b1, V_UNKNOWN, 2);

      clear_line();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         send_request(dir_rows[i].code, dir_rows[i].has, dir_rows[i].eol);
         if (dir_rows[i].typed) begin
            pending_tokens[pending_tokens.size() - 1] = dir_rows[i].want;
         end
      end
      wait_drained();

      // Random lines
      sent_items = 0;
      line_no    = 0;
      while (sent_items < RANDOM_ITEMS) begin
         build_line();
         send_quiet = $urandom_range(0, 99) < 15;
         recv_quiet = $urandom_range(0, 99) < 15;
         if (line_no == 3) begin
            // receiver stalls long while requests keep coming: queue fills, full rises
            rsp_hold   = 1'b1;
            send_quiet = 1'b1;
            send_line();
            build_line();
            send_line();
            build_line();
         end
         send_line();
         line_no++;
         if (line_no % 12 == 0) begin
            wait_drained();
         end
      end
      send_quiet = 1'b0;
      recv_quiet = 1'b0;
      wait_drained();

      // Nesting one past the limit: 256 open parens
      line_buf.delete();
      repeat (DEPTH_LIMIT + 1) line_buf.push_back(CH_LPAR);
      send_line();

      wait_drained();
      repeat (DRAIN_TAIL) @(posedge clock);
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // ---------------------------------------------------------------
   // Result side: random pops, compare against the oldest owed result
   // ---------------------------------------------------------------
   function void log_mismatch(string what, lex_result_type want, lex_result_type got);
      mismatches++;
      if (mismatches <= BAD_SHOWN) begin
         $display("%0t %0s: want kind %0d start %0d len %0d verdict %0d last %0d,",
                  $realtime, what, want.kind, want.start, want.length, want.verdict,
                  want.is_last);
         $display("   got kind %0d start %0d len %0d verdict %0d last %0d",
                  got.kind, got.start, got.length, got.verdict, got.is_last);
      end
   endfunction

   initial begin : result_side
      int             wait_cycles;
      lex_result_type got;
      lex_result_type want;
      while (reset) @(negedge clock);
      forever begin
         wait_cycles = recv_quiet ? 0 : $urandom_range(0, 14);
         if (rsp_hold) begin
            wait_cycles = HOLD_CYCLES;
            rsp_hold    = 1'b0;
         end
         if (wait_cycles > 0) begin
            @(negedge clock);
            rsp_pop <= 1'b0;
            repeat (wait_cycles - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_pop <= 1'b1;
         @(posedge clock);
         while (rsp_empty) @(posedge clock);
         got.kind    = rsp_token_kind;
         got.start   = rsp_token_start;
         got.length  = rsp_token_length;
         got.verdict = rsp_verdict;
         got.is_last = rsp_is_last;
         if (pending_tokens.size() == 0) begin
            log_mismatch("unexpected result", '0, got);
         end else begin
            want = pending_tokens.pop_front();
            if (want != got) begin
               log_mismatch("mismatch", want, got);
            end
         end
      end
   end

endmodule

@@ sim.f @@
hw/rtl/elv_pkg.sv
hw/rtl/elv_front.sv
hw/rtl/elv_queue.sv
hw/rtl/elv_back.sv
hw/rtl/expression_lexer_validator.sv
bench/expression_lexer_validator_tb.sv
